[hdl/level_pool_reservoir_routing_defines.svh]
// Assertion macros shared by the reservoir routing RTL.
// Used by modules that have a clock and a reset signal in scope.
`ifndef LEVEL_POOL_RESERVOIR_ROUTING_DEFINES_SVH
`define LEVEL_POOL_RESERVOIR_ROUTING_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define LPRR_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lprr assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LPRR_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lprr assertion failed");

`endif

[hdl/lprr_pkg.sv]
// Shared types and constants of the reservoir routing block.
// No dependencies.
`timescale 1ns / 1ps
package lprr_pkg;

   localparam int DATA_W         = 32;
   localparam int DEF_TABLE_ROWS = 16;
   localparam int CSR_IDX_W      = 2;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_ROUTE   = 2'd1,
      MODE_RESTART = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS = 2'd0,
      CSR_DT   = 2'd1,
      CSR_H0   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_DIV_LOAD,
      OP_LOAD_WR,
      OP_RESTART,
      OP_SUM,
      OP_CMP,
      OP_CAP_HI,
      OP_CAP_LO,
      OP_MUL,
      OP_DIV_INT,
      OP_INTERP,
      OP_DIV_STO,
      OP_FIN
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic zero_span;
      logic div_busy;
      logic first;
   } status_type;

endpackage

[hdl/lprr_if.sv]
// Channel interfaces of the reservoir routing block: request, response, CSR write.
// Depends on lprr_pkg.
`timescale 1ns / 1ps
interface lprr_req_if import lprr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic [3:0]               row_index;
   logic signed [DATA_W-1:0] row_elevation;
   logic signed [DATA_W-1:0] row_discharge;
   logic signed [DATA_W-1:0] row_storage;
   logic signed [DATA_W-1:0] inflow;

   modport source (output valid, mode, row_index, row_elevation, row_discharge,
                   row_storage, inflow, input ready);
   modport sink (input valid, mode, row_index, row_elevation, row_discharge,
                 row_storage, inflow, output ready);
endinterface

interface lprr_rsp_if import lprr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] outflow;
   logic signed [DATA_W-1:0] water_elevation;
   logic                     out_of_table;

   modport source (output valid, outflow, water_elevation, out_of_table, input ready);
   modport sink (input valid, outflow, water_elevation, out_of_table, output ready);
endinterface

interface lprr_csr_if import lprr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hdl/level_pool_reservoir_routing.sv]
// Channel   | Direction | Beat contents
// req_bus   | in        | mode, row_index, row_elevation, row_discharge, row_storage, inflow
// rsp_bus   | out       | outflow, water_elevation, out_of_table
// csr_bus   | in        | index, data (always ready)
// A load beat runs the 64-step serial divider for 2S/dt before writing the row.
// A route beat scans the rows in use, then runs up to two serial interpolation divisions,
// and one more division for 2S/dt on the first step after a restart.
// A restart beat clears the run state. Reset is synchronous and clears run state and registers.
// One beat is in work at a time; a finished response waits in the output register.
// Depends on lprr_pkg, lprr_if, lprr_ctrl, lprr_dpath.
`timescale 1ns / 1ps
module level_pool_reservoir_routing import lprr_pkg::*; #(
   parameter int TABLE_ROWS = DEF_TABLE_ROWS
) (
   input logic        clock,
   input logic        reset,
   lprr_req_if.sink   req_bus,
   lprr_rsp_if.source rsp_bus,
   lprr_csr_if.sink   csr_bus
);

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   lprr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lprr_dpath #(
      .TABLE_ROWS (TABLE_ROWS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_bus.valid),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .row_index       (req_bus.row_index),
      .row_elevation   (req_bus.row_elevation),
      .row_discharge   (req_bus.row_discharge),
      .row_storage     (req_bus.row_storage),
      .inflow          (req_bus.inflow),
      .outflow         (rsp_bus.outflow),
      .water_elevation (rsp_bus.water_elevation),
      .out_of_table    (rsp_bus.out_of_table)
   );

endmodule

[hdl/lprr_div.sv]
// Restoring unsigned divider, one quotient bit per cycle, 64 bit dividend.
// Depends on lprr_pkg.
`timescale 1ns / 1ps
module lprr_div import lprr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [63:0]         dividend,
   input  logic [DATA_W-1:0]   divisor,
   output logic                busy,
   output logic [63:0]         quotient
);

   logic [63:0]       quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dsr_ff;
   logic [5:0]        cnt_ff;
   logic              busy_ff;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = (shifted >= {1'b0, dsr_ff});
      rem_in  = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_in  = {quo_ff[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[hdl/lprr_dpath.sv]
// Datapath: configuration registers, row tables, search, interpolation and balance.
// Depends on lprr_pkg and lprr_div.
`timescale 1ns / 1ps
module lprr_dpath import lprr_pkg::*; #(
   parameter int TABLE_ROWS = DEF_TABLE_ROWS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data,
   input  logic [3:0]               row_index,
   input  logic signed [DATA_W-1:0] row_elevation,
   input  logic signed [DATA_W-1:0] row_discharge,
   input  logic signed [DATA_W-1:0] row_storage,
   input  logic signed [DATA_W-1:0] inflow,
   output logic signed [DATA_W-1:0] outflow,
   output logic signed [DATA_W-1:0] water_elevation,
   output logic                     out_of_table
);

   localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

   function automatic logic signed [47:0] ext48(input logic signed [DATA_W-1:0] v);
      return 48'(v);
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [47:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 48'sh0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -48'sh0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [DATA_W:0] mag2(input logic signed [DATA_W-1:0] v);
      logic signed [DATA_W:0] t;
      t = {v, 1'b0};
      return (t < 0) ? DATA_W'(0) + (-t) : t;
   endfunction

   function automatic logic [DATA_W-1:0] mag33(input logic signed [DATA_W:0] v);
      logic signed [DATA_W:0] t;
      t = (v < 0) ? -v : v;
      return t[DATA_W-1:0];
   endfunction

   // Configuration.
   logic [4:0]               rows_ff;
   logic [16:0]              dt_ff;
   logic signed [DATA_W-1:0] h0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 5'd2;
         dt_ff   <= 17'd3600;
         h0_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= csr_data[4:0];
            CSR_DT:   dt_ff   <= csr_data[16:0];
            CSR_H0:   h0_ff   <= csr_data;
            default:  ;
         endcase
      end
   end

   logic [16:0]   dtv;
   logic [AW-1:0] last;

   always_comb begin
      dtv = (dt_ff == '0) ? 17'd1 : dt_ff;
      if (rows_ff < 5'd2) begin
         last = AW'(1);
      end else if (int'(rows_ff) > TABLE_ROWS) begin
         last = AW'(TABLE_ROWS - 1);
      end else begin
         last = AW'(rows_ff - 5'd1);
      end
   end

   // Item registers.
   logic [3:0]               idx_ff;
   logic signed [DATA_W-1:0] rel_ff, rdis_ff, rsto_ff, qin_ff;
   logic                     first_ff;
   logic                     started_ff;
   logic signed [DATA_W-1:0] pi_ff, pb_ff;

   // Row tables.
   logic signed [DATA_W-1:0] el_mem  [TABLE_ROWS];
   logic signed [DATA_W-1:0] dis_mem [TABLE_ROWS];
   logic signed [DATA_W-1:0] sto_mem [TABLE_ROWS];
   logic signed [DATA_W-1:0] sd_mem  [TABLE_ROWS];
   logic signed [DATA_W-1:0] rd_el_ff, rd_dis_ff, rd_sto_ff, rd_sd_ff;
   logic [AW-1:0]            cnt_ff;
   logic [AW-1:0]            hit_ff;
   logic                     found_ff;

   // Search and interpolation.
   logic signed [DATA_W-1:0] x_ff, xl_ff, xh_ff, al_ff, ah_ff, bl_ff, bh_ff;
   logic                     lt0_ff, outside_ff;
   logic [63:0]              prod_ff;
   logic [DATA_W-1:0]        dsor_ff;
   logic                     zero_ff, neg_ff, dneg_ff;
   logic signed [DATA_W-1:0] y0_ff, ra_ff, rb_ff;
   logic signed [DATA_W-1:0] out_q_ff, out_h_ff;
   logic                     out_o_ff;

   // Divider.
   logic [63:0]       div_a;
   logic [DATA_W-1:0] div_b;
   logic              div_start, div_busy;
   logic [63:0]       quo;

   lprr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .quotient (quo)
   );

   always_comb begin
      div_a     = prod_ff;
      div_b     = dsor_ff;
      div_start = 1'b0;
      case (cmd.op)
         OP_DIV_LOAD: begin
            div_a     = {31'd0, mag2(rsto_ff)};
            div_b     = {15'd0, dtv};
            div_start = 1'b1;
         end
         OP_DIV_STO: begin
            div_a     = {31'd0, mag2(ra_ff)};
            div_b     = {15'd0, dtv};
            div_start = 1'b1;
         end
         OP_DIV_INT: div_start = 1'b1;
         default: ;
      endcase
   end

   // Combinational helpers.
   logic signed [47:0]       tq;
   logic signed [DATA_W-1:0] xv, sd_val, y0, y1, stq, interp_res;
   logic signed [DATA_W:0]   da, db, dd;
   logic                     le, lt, is_last, lt0_now;
   logic [40:0]              qcap;
   logic signed [47:0]       qs;

   always_comb begin
      tq      = dneg_ff ? -$signed({15'd0, quo[32:0]}) : $signed({15'd0, quo[32:0]});
      sd_val  = sat32(tq + ext48(rdis_ff));
      xv      = first_ff ? rd_el_ff : rd_sd_ff;
      le      = (x_ff <= xv);
      lt      = (x_ff < xv);
      is_last = (cnt_ff == last);
      lt0_now = (cnt_ff == '0) ? lt : lt0_ff;
      y0      = cmd.sel ? bl_ff : al_ff;
      y1      = cmd.sel ? bh_ff : ah_ff;
      da      = (DATA_W+1)'(y1) - (DATA_W+1)'(y0);
      db      = (DATA_W+1)'(x_ff) - (DATA_W+1)'(xl_ff);
      dd      = (DATA_W+1)'(xh_ff) - (DATA_W+1)'(xl_ff);
      qcap    = (quo > 64'h0000_0100_0000_0000) ? 41'h100_0000_0000 : quo[40:0];
      qs      = $signed({7'd0, qcap});
      interp_res = zero_ff ? y0_ff
                 : sat32(neg_ff ? ext48(y0_ff) - qs : ext48(y0_ff) + qs);
      stq     = sat32(ext48(qin_ff) + tq - ext48(rb_ff));
   end

   always_ff @(posedge clock) begin
      rd_el_ff  <= el_mem[cnt_ff];
      rd_dis_ff <= dis_mem[cnt_ff];
      rd_sto_ff <= sto_mem[cnt_ff];
      rd_sd_ff  <= sd_mem[cnt_ff];
      case (cmd.op)
         OP_LATCH: begin
            idx_ff   <= row_index;
            rel_ff   <= row_elevation;
            rdis_ff  <= row_discharge;
            rsto_ff  <= row_storage;
            qin_ff   <= inflow;
            first_ff <= !started_ff;
         end
         OP_LOAD_WR: begin
            if (int'(idx_ff) < TABLE_ROWS) begin
               el_mem[AW'(idx_ff)]  <= rel_ff;
               dis_mem[AW'(idx_ff)] <= rdis_ff;
               sto_mem[AW'(idx_ff)] <= rsto_ff;
               sd_mem[AW'(idx_ff)]  <= sd_val;
            end
         end
         OP_SUM: begin
            x_ff     <= first_ff ? h0_ff : sat32(ext48(pi_ff) + ext48(qin_ff) + ext48(pb_ff));
            cnt_ff   <= '0;
            found_ff <= 1'b0;
         end
         OP_CMP: begin
            lt0_ff <= lt0_now;
            if (le && !found_ff) begin
               found_ff <= 1'b1;
               hit_ff   <= cnt_ff;
            end
            if (is_last) begin
               outside_ff <= lt0_now || !le;
               if (found_ff) begin
                  cnt_ff <= (hit_ff == '0) ? AW'(1) : hit_ff;
               end
            end else begin
               cnt_ff <= cnt_ff + AW'(1);
            end
         end
         OP_CAP_HI: begin
            xh_ff  <= xv;
            ah_ff  <= first_ff ? rd_sto_ff : rd_dis_ff;
            bh_ff  <= first_ff ? rd_dis_ff : rd_el_ff;
            cnt_ff <= cnt_ff - AW'(1);
         end
         OP_CAP_LO: begin
            xl_ff <= xv;
            al_ff <= first_ff ? rd_sto_ff : rd_dis_ff;
            bl_ff <= first_ff ? rd_dis_ff : rd_el_ff;
         end
         OP_MUL: begin
            prod_ff <= mag33(da) * mag33(db);
            dsor_ff <= mag33(dd);
            zero_ff <= (dd == '0);
            neg_ff  <= da[DATA_W] ^ db[DATA_W] ^ dd[DATA_W];
            y0_ff   <= y0;
         end
         OP_INTERP: begin
            if (cmd.sel) begin
               rb_ff <= interp_res;
            end else begin
               ra_ff <= interp_res;
            end
         end
         OP_FIN: begin
            out_o_ff <= outside_ff;
            if (first_ff) begin
               out_q_ff <= rb_ff;
               out_h_ff <= x_ff;
            end else begin
               out_q_ff <= ra_ff;
               out_h_ff <= rb_ff;
            end
         end
         default: ;
      endcase
      if (cmd.op == OP_DIV_LOAD) begin
         dneg_ff <= rsto_ff[DATA_W-1];
      end else if (cmd.op == OP_DIV_STO) begin
         dneg_ff <= ra_ff[DATA_W-1];
      end
   end

   // Run state.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pi_ff      <= '0;
         pb_ff      <= '0;
      end else if (cmd.op == OP_RESTART) begin
         started_ff <= 1'b0;
         pi_ff      <= '0;
         pb_ff      <= '0;
      end else if (cmd.op == OP_FIN) begin
         started_ff <= 1'b1;
         pi_ff      <= qin_ff;
         if (first_ff) begin
            pb_ff <= sat32(ext48(stq) - (ext48(rb_ff) + ext48(rb_ff)));
         end else begin
            pb_ff <= sat32(ext48(x_ff) - (ext48(ra_ff) + ext48(ra_ff)));
         end
      end
   end

   assign status.scan_done = is_last;
   assign status.zero_span = zero_ff;
   assign status.div_busy  = div_busy;
   assign status.first     = first_ff;

   assign outflow         = out_q_ff;
   assign water_elevation = out_h_ff;
   assign out_of_table    = out_o_ff;

endmodule

[hdl/lprr_ctrl.sv]
// Controller state machine: sequences loads, restarts and route steps.
// Depends on lprr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "level_pool_reservoir_routing_defines.svh"
module lprr_ctrl import lprr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_LDIV,
      S_LWAIT,
      S_RESTART,
      S_SUM,
      S_SWAIT,
      S_CMP,
      S_HWAIT,
      S_HCAP,
      S_LOWAIT,
      S_LCAP,
      S_MUL,
      S_DIVS,
      S_DWAIT,
      S_FIN_I,
      S_DIV2S,
      S_D2WAIT,
      S_OUT
   } state_type;

   state_type state_ff;
   logic      sel_ff;
   logic      out_valid_ff;
   logic      accept;
   logic      div_cmd;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign div_cmd   = (cmd.op == OP_DIV_LOAD) || (cmd.op == OP_DIV_INT) ||
                      (cmd.op == OP_DIV_STO);

   always_comb begin
      cmd.op  = OP_NONE;
      cmd.sel = sel_ff;
      case (state_ff)
         S_IDLE:    cmd.op = accept ? OP_LATCH : OP_NONE;
         S_LDIV:    cmd.op = OP_DIV_LOAD;
         S_LWAIT:   cmd.op = status.div_busy ? OP_NONE : OP_LOAD_WR;
         S_RESTART: cmd.op = OP_RESTART;
         S_SUM:     cmd.op = OP_SUM;
         S_CMP:     cmd.op = OP_CMP;
         S_HCAP:    cmd.op = OP_CAP_HI;
         S_LCAP:    cmd.op = OP_CAP_LO;
         S_MUL:     cmd.op = OP_MUL;
         S_DIVS:    cmd.op = status.zero_span ? OP_NONE : OP_DIV_INT;
         S_FIN_I:   cmd.op = OP_INTERP;
         S_DIV2S:   cmd.op = OP_DIV_STO;
         S_OUT:     cmd.op = (!out_valid_ff || rsp_ready) ? OP_FIN : OP_NONE;
         default:   cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!out_valid_ff || rsp_ready)) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_mode)
                     MODE_LOAD:    state_ff <= S_LDIV;
                     MODE_ROUTE:   state_ff <= S_SUM;
                     MODE_RESTART: state_ff <= S_RESTART;
                     default:      state_ff <= S_IDLE;
                  endcase
               end
            end
            S_LDIV:    state_ff <= S_LWAIT;
            S_LWAIT:   if (!status.div_busy) state_ff <= S_IDLE;
            S_RESTART: state_ff <= S_IDLE;
            S_SUM:     state_ff <= S_SWAIT;
            S_SWAIT:   state_ff <= S_CMP;
            S_CMP:     state_ff <= status.scan_done ? S_HWAIT : S_SWAIT;
            S_HWAIT:   state_ff <= S_HCAP;
            S_HCAP:    state_ff <= S_LOWAIT;
            S_LOWAIT:  state_ff <= S_LCAP;
            S_LCAP: begin
               sel_ff   <= 1'b0;
               state_ff <= S_MUL;
            end
            S_MUL:     state_ff <= S_DIVS;
            S_DIVS:    state_ff <= status.zero_span ? S_FIN_I : S_DWAIT;
            S_DWAIT:   if (!status.div_busy) state_ff <= S_FIN_I;
            S_FIN_I: begin
               if (!sel_ff) begin
                  sel_ff   <= 1'b1;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= status.first ? S_DIV2S : S_OUT;
               end
            end
            S_DIV2S:   state_ff <= S_D2WAIT;
            S_D2WAIT:  if (!status.div_busy) state_ff <= S_OUT;
            S_OUT: begin
               if (!out_valid_ff || rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

   `LPRR_ASSERT_IMP(a_no_overwrite, cmd.op == OP_FIN, !out_valid_ff || rsp_ready)
   `LPRR_ASSERT_IMP(a_div_idle, div_cmd, !status.div_busy)
   `LPRR_ASSERT_NXT(a_route_start, accept && req_mode == MODE_ROUTE, state_ff == S_SUM)
   `LPRR_ASSERT_NXT(a_div_hold, state_ff == S_DWAIT && status.div_busy, state_ff == S_DWAIT)

endmodule
